// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of the float conversion core.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Whenever the antecedent holds, the consequent must hold at the same edge.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: hdl/fxf_pkg.sv
// Shared types and constants of the fixed-point to IEEE754 conversion core.
// Depends on nothing; imported by fxf_pack, the top level and the checker.
package fxf_pkg;

   // Default widths of the fixed-point magnitude.
   localparam int INT_BITS_DEF  = 32;
   localparam int FRAC_BITS_DEF = 52;

   // Target format codes.
   typedef enum logic [1:0] {
      FMT_HALF   = 2'd0,
      FMT_SINGLE = 2'd1,
      FMT_DOUBLE = 2'd2
   } fmt_type;

   // Field widths of the three formats.
   localparam int HALF_MBITS   = 10;
   localparam int HALF_EBITS   = 5;
   localparam int SINGLE_MBITS = 23;
   localparam int SINGLE_EBITS = 8;
   localparam int DOUBLE_MBITS = 52;
   localparam int DOUBLE_EBITS = 11;

   localparam int HALF_BIAS   = (1 << (HALF_EBITS - 1)) - 1;
   localparam int SINGLE_BIAS = (1 << (SINGLE_EBITS - 1)) - 1;
   localparam int DOUBLE_BIAS = (1 << (DOUBLE_EBITS - 1)) - 1;

   // Largest biased exponent of a normal number.
   localparam int HALF_EMAX   = (1 << HALF_EBITS) - 2;
   localparam int SINGLE_EMAX = (1 << SINGLE_EBITS) - 2;
   localparam int DOUBLE_EMAX = (1 << DOUBLE_EBITS) - 2;

   localparam int WORD_BITS = 64;

   // One packed result with its status flags.
   typedef struct packed {
      logic [WORD_BITS-1:0] word;
      logic                 ovf;
      logic                 unf;
   } result_type;

endpackage

// File: hdl/fxf_lzd.sv
// Leading-one detector for the fixed-point magnitude of the conversion core.
// Depends on nothing outside this file.
module fxf_lzd #(
   parameter int W = 84
) (
   input  logic [W-1:0]         mag,
   output logic [$clog2(W)-1:0] lead,
   output logic                 zero
);

   localparam int LIW = $clog2(W);

   // Ascending scan: the highest set bit is the last one to write the index.
   always_comb begin
      lead = '0;
      for (int i = 0; i < W; i++) begin
         if (mag[i]) begin
            lead = LIW'(i);
         end
      end
      zero = (mag == '0);
   end

endmodule

// File: hdl/fxf_pack.sv
// Normalizing shift, exponent range check and IEEE754 packing.
// Depends on fxf_pkg for the format codes, field widths and result struct.
module fxf_pack #(
   parameter int INT_BITS  = fxf_pkg::INT_BITS_DEF,
   parameter int FRAC_BITS = fxf_pkg::FRAC_BITS_DEF
) (
   input  logic [1:0]                              op,
   input  logic                                    sign,
   input  logic [INT_BITS+FRAC_BITS-1:0]           mag,
   input  logic [$clog2(INT_BITS+FRAC_BITS)-1:0]   lead,
   input  logic                                    zero,
   output fxf_pkg::result_type                     result
);

   import fxf_pkg::*;

   localparam int W   = INT_BITS + FRAC_BITS;
   localparam int LIW = $clog2(W);
   localparam int NW  = W + DOUBLE_MBITS;
   localparam int BW  = $clog2(W + 2048) + 1;

   logic [LIW-1:0]          shift;
   logic [NW-1:0]           norm;
   logic signed [BW-1:0]    bias_v;
   logic signed [BW-1:0]    emax_v;
   logic signed [BW-1:0]    biased;
   logic                    ovf;
   logic                    unf;
   logic                    normal;
   logic [DOUBLE_EBITS-1:0] exp_field;
   logic [HALF_MBITS-1:0]   mant_h;
   logic [SINGLE_MBITS-1:0] mant_s;
   logic [DOUBLE_MBITS-1:0] mant_d;

   always_comb begin
      // Bring the leading one to the top bit; the bits below it are the mantissa.
      shift = LIW'(W - 1) - lead;
      norm  = {mag, {DOUBLE_MBITS{1'b0}}} << shift;

      case (op)
         FMT_HALF: begin
            bias_v = BW'(HALF_BIAS);
            emax_v = BW'(HALF_EMAX);
         end
         FMT_SINGLE: begin
            bias_v = BW'(SINGLE_BIAS);
            emax_v = BW'(SINGLE_EMAX);
         end
         default: begin
            bias_v = BW'(DOUBLE_BIAS);
            emax_v = BW'(DOUBLE_EMAX);
         end
      endcase

      // The binary point lies FRAC_BITS places above bit 0 of the magnitude.
      biased = $signed(BW'(lead)) + bias_v - $signed(BW'(FRAC_BITS));
      ovf    = !zero && (biased > emax_v);
      unf    = !zero && (biased < $signed(BW'(1)));
      normal = !zero && !ovf && !unf;

      if (ovf) begin
         exp_field = '1;
      end else if (normal) begin
         exp_field = biased[DOUBLE_EBITS-1:0];
      end else begin
         exp_field = '0;
      end

      mant_h = normal ? norm[NW-2 -: HALF_MBITS]   : '0;
      mant_s = normal ? norm[NW-2 -: SINGLE_MBITS] : '0;
      mant_d = normal ? norm[NW-2 -: DOUBLE_MBITS] : '0;

      case (op)
         FMT_HALF: begin
            result.word = {{(WORD_BITS - HALF_MBITS - HALF_EBITS - 1){1'b0}},
                           sign, exp_field[HALF_EBITS-1:0], mant_h};
         end
         FMT_SINGLE: begin
            result.word = {{(WORD_BITS - SINGLE_MBITS - SINGLE_EBITS - 1){1'b0}},
                           sign, exp_field[SINGLE_EBITS-1:0], mant_s};
         end
         default: begin
            result.word = {sign, exp_field, mant_d};
         end
      endcase
      result.ovf = ovf;
      result.unf = unf;
   end

endmodule

// File: hdl/fixed_to_ieee754_float_core.sv
// Top level of the fixed-point to IEEE754 half, single and double converter.
// Depends on fxf_pkg, fxf_lzd and fxf_pack.
//
// The core converts a sign and an unsigned fixed-point magnitude (an integer
// part of INT_BITS bits and a binary fraction of FRAC_BITS bits) into a packed
// IEEE754 word, right aligned for the format chosen by req_opcode (0 half,
// 1 single, 2 or 3 double). The mantissa is truncated, never rounded. A zero
// magnitude gives a signed zero, a value beyond the format's range gives a
// signed infinity with rsp_overflow_flag set, and a nonzero value below the
// smallest normal number gives a signed zero with rsp_underflow_flag set.
// A transfer is taken at every rising edge where start is high and busy is
// low; busy is high only while reset is held, so the core takes one item in
// every clock cycle. Each result passes the input register, the register after
// the leading-one detector and the result register after the normalizing shift
// and packing logic, and appears for one cycle only, marked by rsp_strobe;
// results leave in the order their items came in. The receiver cannot stall the
// core: it must take each result in the cycle that rsp_strobe marks.
module fixed_to_ieee754_float_core #(
   parameter int INT_BITS  = fxf_pkg::INT_BITS_DEF,
   parameter int FRAC_BITS = fxf_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_opcode,
   input  logic                 req_sign_bit,
   input  logic [INT_BITS-1:0]  req_integer_part,
   input  logic [FRAC_BITS-1:0] req_fraction_part,
   output logic                 rsp_strobe,
   output logic [63:0]          rsp_encoded_word,
   output logic                 rsp_overflow_flag,
   output logic                 rsp_underflow_flag
);

   import fxf_pkg::*;

   localparam int W   = INT_BITS + FRAC_BITS;
   localparam int LIW = $clog2(W);

   // The core holds off new items only while it is being reset.
   assign busy = reset;

   logic accept;
   assign accept = start && !busy;

   // Input register stage: the raw item with the magnitude joined into one word.
   logic         a_valid_ff, a_valid_in;
   logic [1:0]   a_op_ff;
   logic         a_sign_ff;
   logic [W-1:0] a_mag_ff;

   // Second stage: the item together with the position of its leading one.
   logic           b_valid_ff, b_valid_in;
   logic [1:0]     b_op_ff;
   logic           b_sign_ff;
   logic [W-1:0]   b_mag_ff;
   logic [LIW-1:0] b_lead_ff, b_lead_in;
   logic           b_zero_ff, b_zero_in;

   // Result register stage.
   logic       c_valid_ff, c_valid_in;
   result_type c_result_ff, c_result_in;

   assign a_valid_in = accept;
   assign b_valid_in = a_valid_ff;
   assign c_valid_in = b_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   // Payload registers follow their valid bits and need no reset.
   always_ff @(posedge clock) begin
      a_op_ff     <= req_opcode;
      a_sign_ff   <= req_sign_bit;
      a_mag_ff    <= {req_integer_part, req_fraction_part};
      b_op_ff     <= a_op_ff;
      b_sign_ff   <= a_sign_ff;
      b_mag_ff    <= a_mag_ff;
      b_lead_ff   <= b_lead_in;
      b_zero_ff   <= b_zero_in;
      c_result_ff <= c_result_in;
   end

   fxf_lzd #(
      .W (W)
   ) u_fxf_lzd (
      .mag  (a_mag_ff),
      .lead (b_lead_in),
      .zero (b_zero_in)
   );

   fxf_pack #(
      .INT_BITS  (INT_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_fxf_pack (
      .op     (b_op_ff),
      .sign   (b_sign_ff),
      .mag    (b_mag_ff),
      .lead   (b_lead_ff),
      .zero   (b_zero_ff),
      .result (c_result_in)
   );

   assign rsp_strobe         = c_valid_ff;
   assign rsp_encoded_word   = c_result_ff.word;
   assign rsp_overflow_flag  = c_result_ff.ovf;
   assign rsp_underflow_flag = c_result_ff.unf;

endmodule

// File: hdl/fxf_checker.sv
// Port-level checker for the conversion core, attached to it by bind below.
// Depends on fxf_pkg and the assertion macros in assert_macros.svh.
`include "assert_macros.svh"

module fxf_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_opcode,
   input logic        rsp_strobe,
   input logic [63:0] rsp_encoded_word,
   input logic        rsp_overflow_flag,
   input logic        rsp_underflow_flag
);

   import fxf_pkg::*;

   // Every transfer later comes out as one result strobe, and nothing else does.
   `ASSERT_IMPLIES(a_strobe_latency, clock, reset, !$past(reset, 1) && !$past(reset, 2), rsp_strobe == $past(start && !busy, 3), "result strobe does not match a transfer three cycles earlier")

   // A result cannot be both too large and too small.
   `ASSERT_ALWAYS(a_flags_exclusive, clock, reset, !(rsp_strobe && rsp_overflow_flag && rsp_underflow_flag), "overflow and underflow flagged together")

   // A flushed result carries at most its sign bit.
   `ASSERT_IMPLIES(a_underflow_zero, clock, reset, rsp_strobe && rsp_underflow_flag, $countones(rsp_encoded_word) <= 1, "underflow result is not a signed zero")

   // Single precision overflow gives exactly infinity.
   `ASSERT_IMPLIES(a_single_inf, clock, reset, rsp_strobe && rsp_overflow_flag && ($past(req_opcode, 3) == FMT_SINGLE), rsp_encoded_word[30:0] == 31'h7F80_0000, "single overflow result is not infinity")

endmodule

bind fixed_to_ieee754_float_core fxf_port_checker u_fxf_port_checker (.*);
